// File: sv/ccse_pkg.sv
`default_nettype none

package ccse_pkg;

  // Field widths fixed by the request and result formats
  localparam int FUNC_W      = 2;
  localparam int VAR_W       = 10;
  localparam int VAL_W       = 2;
  localparam int OUT_COUNT_W = 16;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LITERAL = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  // Three-valued assignment codes; the fourth code is never stored
  localparam logic [VAL_W-1:0] VAL_UNASSIGNED = 2'd0;
  localparam logic [VAL_W-1:0] VAL_TRUE       = 2'd1;
  localparam logic [VAL_W-1:0] VAL_FALSE      = 2'd2;
  localparam logic [VAL_W-1:0] VAL_RESERVED   = 2'd3;

  // Request held in the evaluation stage
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [VAR_W-1:0]  var_index;
    logic              positive;
    logic              last_literal;
    logic              in_range;
  } stage_t;

  // Clause status delivered to the result register
  typedef struct packed {
    logic                   clause_satisfied;
    logic                   clause_unit;
    logic                   clause_conflict;
    logic [VAR_W-1:0]       unit_var;
    logic                   unit_positive;
    logic [OUT_COUNT_W-1:0] satisfied_count;
    logic                   conflict_seen;
    logic                   all_satisfied;
  } result_t;

endpackage

`default_nettype wire

// File: sv/cnf_clause_status_evaluator_unit.sv
// A final literal is held in the evaluation stage, then its result in the result register.
// Throughput: one request per cycle unless stalled; each touches the table at most once.
// Reset: synchronous; afterwards the table is swept to unassigned, one entry per cycle,
// over all min(NUM_VARS, 1024) entries (1024 at the defaults) while req_stall stays high.
// Counters, clause accumulators and both valid flags clear at reset.
`default_nettype none

module cnf_clause_status_evaluator_unit #(
  parameter int NUM_VARS   = 1024,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [ccse_pkg::FUNC_W-1:0]         func,
  input  wire logic [ccse_pkg::VAR_W-1:0]          var_index,
  input  wire logic                                positive,
  input  wire logic [ccse_pkg::VAL_W-1:0]          new_value,
  input  wire logic                                last_literal,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic                                     clause_satisfied,
  output logic                                     clause_unit,
  output logic                                     clause_conflict,
  output logic [ccse_pkg::VAR_W-1:0]               unit_var,
  output logic                                     unit_positive,
  output logic [ccse_pkg::OUT_COUNT_W-1:0]         satisfied_count,
  output logic                                     conflict_seen,
  output logic                                     all_satisfied
);

  localparam int INDEX_SPAN = 1 << ccse_pkg::VAR_W;
  localparam int DEPTH      = (NUM_VARS < INDEX_SPAN) ? NUM_VARS : INDEX_SPAN;
  localparam int ADDR_W     = $clog2(DEPTH);

  logic                         accept;
  logic                         in_range;
  logic [ADDR_W+ccse_pkg::VAR_W-1:0] index_ext;
  logic [ADDR_W-1:0]            index_addr;

  logic                         sweep_busy;
  logic [ADDR_W-1:0]            sweep_addr;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [ccse_pkg::VAL_W-1:0]   ram_wdata;
  logic                         ram_re;
  logic [ccse_pkg::VAL_W-1:0]   ram_rdata;

  logic                         stage_valid;
  ccse_pkg::stage_t             stage;
  logic                         stage_fire;
  logic                         emit;
  ccse_pkg::result_t            result;
  ccse_pkg::result_t            rsp;

  // Request handshake
  assign accept    = req_valid && !req_stall;
  assign req_stall = sweep_busy || (stage_valid && !stage_fire);

  // Table address
  assign in_range   = (32'(var_index) < NUM_VARS);
  assign index_ext  = {{ADDR_W{1'b0}}, var_index};
  assign index_addr = index_ext[ADDR_W-1:0];

  // Sweep the table to unassigned after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_busy <= 1'b1;
      sweep_addr <= '0;
    end else if (sweep_busy) begin
      sweep_addr <= sweep_addr + 1'b1;
      if (sweep_addr == ADDR_W'(DEPTH - 1)) begin
        sweep_busy <= 1'b0;
      end
    end
  end

  // Writes land at acceptance; literals read at acceptance
  assign ram_we    = sweep_busy ||
                     (accept && (func == ccse_pkg::FUNC_WRITE) &&
                      (new_value != ccse_pkg::VAL_RESERVED) && in_range);
  assign ram_waddr = sweep_busy ? sweep_addr : index_addr;
  assign ram_wdata = sweep_busy ? ccse_pkg::VAL_UNASSIGNED : new_value;
  assign ram_re    = accept && (func == ccse_pkg::FUNC_LITERAL);

  ccse_ram #(
    .WIDTH (ccse_pkg::VAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (index_addr),
    .rdata (ram_rdata)
  );

  // Hold literal and clear requests for evaluation
  assign stage_fire = stage_valid && (!emit || !rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= (func == ccse_pkg::FUNC_LITERAL) || (func == ccse_pkg::FUNC_CLEAR);
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage.func         <= func;
      stage.var_index    <= var_index;
      stage.positive     <= positive;
      stage.last_literal <= last_literal;
      stage.in_range     <= in_range;
    end
  end

  ccse_eval #(
    .COUNT_BITS (COUNT_BITS)
  ) u_eval (
    .clk    (clk),
    .rst    (rst),
    .fire   (stage_fire),
    .stage  (stage),
    .value  (ram_rdata),
    .emit   (emit),
    .result (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (stage_fire && emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && emit) begin
      rsp <= result;
    end
  end

  assign clause_satisfied = rsp.clause_satisfied;
  assign clause_unit      = rsp.clause_unit;
  assign clause_conflict  = rsp.clause_conflict;
  assign unit_var         = rsp.unit_var;
  assign unit_positive    = rsp.unit_positive;
  assign satisfied_count  = rsp.satisfied_count;
  assign conflict_seen    = rsp.conflict_seen;
  assign all_satisfied    = rsp.all_satisfied;

endmodule

`default_nettype wire

// File: sv/ccse_ram.sv
`default_nettype none

module ccse_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/ccse_eval.sv
`default_nettype none

module ccse_eval #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            fire,
  input  wire ccse_pkg::stage_t                stage,
  input  wire logic [ccse_pkg::VAL_W-1:0]      value,
  output logic                                 emit,
  output ccse_pkg::result_t                    result
);

  localparam logic [COUNT_BITS-1:0] SAT_MAX = {COUNT_BITS{1'b1}};

  // Clause accumulators
  logic                          any_true, any_true_next;
  logic [1:0]                    open_count, open_count_next;
  logic [ccse_pkg::VAR_W-1:0]    open_var, open_var_next;
  logic                          open_positive, open_positive_next;

  // Pass counters
  logic [COUNT_BITS-1:0]         sat_counter, sat_counter_next;
  logic                          conflict_flag, conflict_flag_next;
  logic                          unsat_flag, unsat_flag_next;

  logic [ccse_pkg::VAL_W-1:0]    lit_value;
  logic                          lit_true;
  logic                          acc_true;
  logic [1:0]                    acc_count;
  logic [ccse_pkg::VAR_W-1:0]    acc_var;
  logic                          acc_positive;
  logic                          sat, unit, conflict;
  logic [COUNT_BITS+ccse_pkg::OUT_COUNT_W-1:0] count_ext;

  assign emit = (stage.func == ccse_pkg::FUNC_LITERAL) && stage.last_literal;

  // Fold the current literal into the clause and close the clause on its last literal
  always_comb begin
    lit_value = stage.in_range ? value : ccse_pkg::VAL_UNASSIGNED;
    lit_true  = (stage.positive && (lit_value == ccse_pkg::VAL_TRUE)) ||
                (!stage.positive && (lit_value == ccse_pkg::VAL_FALSE));

    acc_true     = any_true | lit_true;
    acc_count    = open_count;
    acc_var      = open_var;
    acc_positive = open_positive;
    if (!lit_true && (lit_value == ccse_pkg::VAL_UNASSIGNED)) begin
      if (open_count == 2'd0) begin
        acc_var      = stage.var_index;
        acc_positive = stage.positive;
      end
      if (open_count != 2'd2) begin
        acc_count = open_count + 2'd1;
      end
    end

    sat      = acc_true;
    unit     = !acc_true && (acc_count == 2'd1);
    conflict = !acc_true && (acc_count == 2'd0);

    any_true_next      = any_true;
    open_count_next    = open_count;
    open_var_next      = open_var;
    open_positive_next = open_positive;
    sat_counter_next   = sat_counter;
    conflict_flag_next = conflict_flag;
    unsat_flag_next    = unsat_flag;

    case (stage.func)
      ccse_pkg::FUNC_LITERAL: begin
        if (stage.last_literal) begin
          any_true_next      = 1'b0;
          open_count_next    = 2'd0;
          open_var_next      = '0;
          open_positive_next = 1'b0;
          if (sat) begin
            if (sat_counter != SAT_MAX) begin
              sat_counter_next = sat_counter + 1'b1;
            end
          end else begin
            unsat_flag_next = 1'b1;
          end
          if (conflict) begin
            conflict_flag_next = 1'b1;
          end
        end else begin
          any_true_next      = acc_true;
          open_count_next    = acc_count;
          open_var_next      = acc_var;
          open_positive_next = acc_positive;
        end
      end
      ccse_pkg::FUNC_CLEAR: begin
        any_true_next      = 1'b0;
        open_count_next    = 2'd0;
        open_var_next      = '0;
        open_positive_next = 1'b0;
        sat_counter_next   = '0;
        conflict_flag_next = 1'b0;
        unsat_flag_next    = 1'b0;
      end
      default: begin
      end
    endcase

    count_ext = {{ccse_pkg::OUT_COUNT_W{1'b0}}, sat_counter_next};

    result.clause_satisfied = sat;
    result.clause_unit      = unit;
    result.clause_conflict  = conflict;
    result.unit_var         = unit ? acc_var : '0;
    result.unit_positive    = unit & acc_positive;
    result.satisfied_count  = count_ext[ccse_pkg::OUT_COUNT_W-1:0];
    result.conflict_seen    = conflict_flag_next;
    result.all_satisfied    = !unsat_flag_next;
  end

  // Advance accumulators and counters when the stage retires
  always_ff @(posedge clk) begin
    if (rst) begin
      any_true      <= 1'b0;
      open_count    <= 2'd0;
      open_var      <= '0;
      open_positive <= 1'b0;
      sat_counter   <= '0;
      conflict_flag <= 1'b0;
      unsat_flag    <= 1'b0;
    end else if (fire) begin
      any_true      <= any_true_next;
      open_count    <= open_count_next;
      open_var      <= open_var_next;
      open_positive <= open_positive_next;
      sat_counter   <= sat_counter_next;
      conflict_flag <= conflict_flag_next;
      unsat_flag    <= unsat_flag_next;
    end
  end

endmodule

`default_nettype wire
